>>> sv/spfa_pkg.sv
package spfa_pkg;

  localparam int NODES_DEFAULT     = 16;
  localparam int MAX_EDGES_DEFAULT = 64;
  localparam int WEIGHT_BITS_DEFAULT = 16;

  localparam int OPCODE_W = 2;
  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN   = 2'd2;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [NODE_W-1:0]          edge_from;
    logic [NODE_W-1:0]          edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]          source_node;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0]        node_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;
  } out_word_t;

endpackage

>>> sv/spfa_in_if.sv
interface spfa_in_if;
  logic                valid;
  logic                ready;
  spfa_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/spfa_out_if.sv
interface spfa_out_if;
  logic                valid;
  logic                ready;
  spfa_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/spfa_shortest_paths.sv
// Single-source shortest paths (queue-based Bellman-Ford) over a stored edge list.
// Channels: in (sink) takes one command word: clear edges, add edge, or run
// from source_node; out (source) gives one word per node after a run.
// Clear and add give no word; in.ready stays high, so the next word can be taken
// in the following cycle. Add is dropped when the list is full or a node index
// is out of range.
// A run, once accepted, resets node state one node at a time, then for every
// queue pop goes through each stored edge in turn (the edge memory
// has one registered read port; each edge is read, then relaxed through one
// adder/compare), then finds the queue empty, then gives NODES output
// words, one per cycle while out.ready is high.
// A node relaxed NODES times stops the run; all words then carry
// negative_cycle. last marks the word of node NODES-1.
// in.ready is low from run start until the last output word is taken.
// A stall on out holds the current word; nothing is dropped.
// Reset empties the edge list and returns to idle.
module spfa_shortest_paths #(
  parameter int NODES       = spfa_pkg::NODES_DEFAULT,
  parameter int MAX_EDGES   = spfa_pkg::MAX_EDGES_DEFAULT,
  parameter int WEIGHT_BITS = spfa_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  spfa_in_if.sink     in,
  spfa_out_if.source  out
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int FW = $clog2(NODES + 1);
  localparam int RW = $clog2(NODES + 1);
  localparam int DW = spfa_pkg::DIST_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_EDGE  = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;

  logic [NW-1:0]          efrom_mem [MAX_EDGES];
  logic [NW-1:0]          eto_mem   [MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] ew_mem [MAX_EDGES];
  logic [CW-1:0]          edge_count;

  logic signed [DW-1:0]   node_dist [NODES];
  logic [NODES-1:0]       reached;
  logic [NODES-1:0]       in_q;
  logic [RW-1:0]          relax_cnt [NODES];
  logic [NW-1:0]          queue     [NODES];
  logic [NW-1:0]          qhead;
  logic [FW-1:0]          qfill;

  logic [NW-1:0]          cur;
  logic signed [DW-1:0]   cur_dist;
  logic [CW-1:0]          eidx;
  logic [NW-1:0]          rd_from;
  logic [NW-1:0]          rd_to;
  logic signed [WEIGHT_BITS-1:0] rd_w;
  logic [NW-1:0]          nidx;
  logic                   neg;
  logic                   src_ok;
  logic [NW-1:0]          src;

  logic [FW:0]            qsum;
  logic [NW-1:0]          qtail;
  logic signed [DW+1:0]   sum;
  logic signed [DW-1:0]   cand;
  logic                   improve;

  assign in.ready = (state == S_IDLE);
  assign qsum  = (FW+1)'(qhead) + (FW+1)'(qfill);
  assign qtail = (32'(qsum) >= NODES) ? NW'(32'(qsum) - NODES) : NW'(qsum);

  always_comb begin
    sum = (DW+2)'(cur_dist) + (DW+2)'(rd_w);
    if (sum > (DW+2)'(spfa_pkg::DIST_MAX)) begin
      cand = spfa_pkg::DIST_MAX;
    end else if (sum < (DW+2)'(spfa_pkg::DIST_MIN)) begin
      cand = spfa_pkg::DIST_MIN;
    end else begin
      cand = DW'(sum);
    end
    improve = !reached[rd_to] || (cand < node_dist[rd_to]);
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in.valid && in.data.opcode == spfa_pkg::OP_ADD &&
        edge_count < CW'(MAX_EDGES) && 32'(in.data.edge_from) < NODES &&
        32'(in.data.edge_to) < NODES) begin
      efrom_mem[EW'(edge_count)] <= NW'(in.data.edge_from);
      eto_mem[EW'(edge_count)]   <= NW'(in.data.edge_to);
      ew_mem[EW'(edge_count)]    <= WEIGHT_BITS'(in.data.edge_weight);
    end
    rd_from <= efrom_mem[EW'(eidx)];
    rd_to   <= eto_mem[EW'(eidx)];
    rd_w    <= ew_mem[EW'(eidx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_count <= '0;
      reached    <= '0;
      in_q       <= '0;
      qfill      <= '0;
      qhead      <= '0;
      nidx       <= '0;
      neg        <= 1'b0;
      out.valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            unique case (in.data.opcode)
              spfa_pkg::OP_CLEAR: edge_count <= '0;
              spfa_pkg::OP_ADD: begin
                if (edge_count < CW'(MAX_EDGES) && 32'(in.data.edge_from) < NODES &&
                    32'(in.data.edge_to) < NODES) begin
                  edge_count <= edge_count + 1'b1;
                end
              end
              spfa_pkg::OP_RUN: begin
                src     <= NW'(in.data.source_node);
                src_ok  <= 32'(in.data.source_node) < NODES;
                nidx    <= '0;
                neg     <= 1'b0;
                reached <= '0;
                in_q    <= '0;
                state   <= S_INIT;
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          relax_cnt[nidx] <= '0;
          if (32'(nidx) == NODES - 1) begin
            qhead <= '0;
            nidx  <= '0;
            if (src_ok) begin
              node_dist[src] <= '0;
              reached[src]   <= 1'b1;
              in_q[src]      <= 1'b1;
              queue[0]       <= src;
              qfill          <= FW'(1);
              state          <= S_POP;
            end else begin
              qfill     <= '0;
              state     <= S_OUT;
              out.valid <= 1'b1;
            end
          end else begin
            nidx <= nidx + 1'b1;
          end
        end
        S_POP: begin
          if (qfill == '0) begin
            nidx      <= '0;
            state     <= S_OUT;
            out.valid <= 1'b1;
          end else begin
            cur         <= queue[qhead];
            cur_dist    <= node_dist[queue[qhead]];
            in_q[queue[qhead]] <= 1'b0;
            qhead       <= (32'(qhead) == NODES - 1) ? '0 : qhead + 1'b1;
            qfill       <= qfill - 1'b1;
            eidx        <= '0;
            state       <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (eidx >= edge_count) begin
            state <= S_POP;
          end else begin
            eidx  <= eidx + 1'b1;
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (rd_from == cur && improve) begin
            node_dist[rd_to] <= cand;
            reached[rd_to]   <= 1'b1;
            relax_cnt[rd_to] <= relax_cnt[rd_to] + 1'b1;
            if (32'(relax_cnt[rd_to]) + 1 >= NODES) begin
              neg       <= 1'b1;
              nidx      <= '0;
              state     <= S_OUT;
              out.valid <= 1'b1;
            end else begin
              state <= S_EDGE;
              if (!in_q[rd_to]) begin
                queue[qtail] <= rd_to;
                in_q[rd_to]  <= 1'b1;
                qfill        <= qfill + 1'b1;
              end
            end
            if (rd_to == cur) begin
              cur_dist <= cand;
            end
          end else begin
            state <= S_EDGE;
          end
        end
        S_OUT: begin
          if (out.ready) begin
            nidx <= nidx + 1'b1;
            if (32'(nidx) == NODES - 1) begin
              out.valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out.data.node_index     = spfa_pkg::NODE_W'(nidx);
    out.data.distance       = reached[nidx] ? node_dist[nidx] : '0;
    out.data.reachable      = reached[nidx];
    out.data.negative_cycle = neg;
    out.data.last           = (32'(nidx) == NODES - 1);
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("input taken during output");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(qfill) <= NODES) else $error("queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= MAX_EDGES) else $error("edge count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(nidx)) else $error("word lost");
`endif

endmodule

>>> sim/tb_spfa_shortest_paths.sv
`timescale 1ns / 100ps

module tb_spfa_shortest_paths;

  localparam int NODES = spfa_pkg::NODES_DEFAULT;
  localparam int MAX_EDGES = spfa_pkg::MAX_EDGES_DEFAULT;
  localparam int PAUSE_CYCLES = 400;
  localparam logic [spfa_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spfa_in_if  in_ch ();
  spfa_out_if out_ch ();

  spfa_shortest_paths u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spfa_pkg::in_word_t  cmd_q[$];
  spfa_pkg::out_word_t exp_q[$];
  int        fail_cnt = 0;
  bit        stim_done = 1'b0;
  logic      in_taken;

  logic [spfa_pkg::NODE_W-1:0]          e_from[MAX_EDGES];
  logic [spfa_pkg::NODE_W-1:0]          e_to[MAX_EDGES];
  logic signed [spfa_pkg::WEIGHT_W-1:0] e_wt[MAX_EDGES];
  int                                   e_cnt = 0;

  function automatic logic signed [spfa_pkg::DIST_W-1:0] sat_dist(longint v);
    if (v > longint'(spfa_pkg::DIST_MAX)) return spfa_pkg::DIST_MAX;
    if (v < longint'(spfa_pkg::DIST_MIN)) return spfa_pkg::DIST_MIN;
    return v[spfa_pkg::DIST_W-1:0];
  endfunction

  task automatic predict_word(spfa_pkg::in_word_t w);
    logic signed [spfa_pkg::DIST_W-1:0] node_dist[NODES];
    bit   reached[NODES];
    bit   queued[NODES];
    int   relax[NODES];
    int   fifo[$];
    int   cur;
    int   dst;
    bit   neg;
    logic signed [spfa_pkg::DIST_W-1:0] cand;
    spfa_pkg::out_word_t r;
    neg = 1'b0;
    case (w.opcode)
      spfa_pkg::OP_CLEAR: e_cnt = 0;
      spfa_pkg::OP_ADD: begin
        if (e_cnt < MAX_EDGES && int'(w.edge_from) < NODES && int'(w.edge_to) < NODES) begin
          e_from[e_cnt] = w.edge_from;
          e_to[e_cnt] = w.edge_to;
          e_wt[e_cnt] = w.edge_weight;
          e_cnt++;
        end
      end
      spfa_pkg::OP_RUN: begin
        for (int n = 0; n < NODES; n++) begin
          node_dist[n] = '0;
          reached[n] = 0;
          queued[n] = 0;
          relax[n] = 0;
        end
        if (int'(w.source_node) < NODES) begin
          reached[w.source_node] = 1;
          queued[w.source_node] = 1;
          fifo = {fifo, int'(w.source_node)};
        end
        while (fifo.size() > 0 && !neg) begin
          cur = fifo.pop_front();
          queued[cur] = 0;
          for (int i = 0; i < e_cnt && !neg; i++) begin
            if (e_from[i] == cur) begin
              dst = e_to[i];
              cand = sat_dist(longint'(node_dist[cur]) + longint'(e_wt[i]));
              if (!(reached[dst] && cand >= node_dist[dst])) begin
                node_dist[dst] = cand;
                reached[dst] = 1;
                relax[dst]++;
                if (relax[dst] >= NODES) neg = 1'b1;
                else if (!queued[dst]) begin
                  queued[dst] = 1;
                  fifo = {fifo, dst};
                end
              end
            end
          end
        end
        for (int n = 0; n < NODES; n++) begin
          r.node_index = n[spfa_pkg::NODE_W-1:0];
          r.distance = reached[n] ? node_dist[n] : '0;
          r.reachable = reached[n];
          r.negative_cycle = neg;
          r.last = (n == NODES - 1);
          exp_q = {exp_q, r};
        end
      end
      default: ;
    endcase
  endtask

  function automatic spfa_pkg::in_word_t make_word(logic [spfa_pkg::OPCODE_W-1:0] op,
                                                   int f, int t, int wt, int s);
    spfa_pkg::in_word_t w;
    w.opcode = op;
    w.edge_from = f[spfa_pkg::NODE_W-1:0];
    w.edge_to = t[spfa_pkg::NODE_W-1:0];
    w.edge_weight = wt[spfa_pkg::WEIGHT_W-1:0];
    w.source_node = s[spfa_pkg::NODE_W-1:0];
    return w;
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535) - 32768;
      1: return 32767;
      2: return -32768;
      3: return -$urandom_range(1, 20);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic queue_cmd(spfa_pkg::in_word_t w);
    cmd_q = {cmd_q, w};
  endtask

  initial begin
    int p;
    queue_cmd(make_word(spfa_pkg::OP_RUN, 0, 0, 0, 3));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 0, 1, 5, 0));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 1, 2, -3, 0));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 2, 3, 7, 0));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 0, 3, 20, 0));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 3, 3, 0, 0));
    queue_cmd(make_word(spfa_pkg::OP_RUN, 0, 0, 0, 0));
    queue_cmd(make_word(spfa_pkg::OP_ADD, 3, 0, -30, 0));
    queue_cmd(make_word(spfa_pkg::OP_RUN, 0, 0, 0, 0));
    queue_cmd(make_word(OP_UNUSED, 1, 2, 3, 4));
    queue_cmd(make_word(spfa_pkg::OP_CLEAR, 0, 0, 0, 0));
    for (int k = 0; k < MAX_EDGES + 6; k++) begin
      queue_cmd(make_word(spfa_pkg::OP_ADD, $urandom_range(0, NODES - 1),
                          $urandom_range(0, NODES - 1), $urandom_range(0, 50), 0));
    end
    queue_cmd(make_word(spfa_pkg::OP_RUN, 0, 0, 0, $urandom_range(0, NODES - 1)));
    queue_cmd(make_word(spfa_pkg::OP_CLEAR, 0, 0, 0, 0));
    for (int k = 0; k < 215; k++) begin
      p = $urandom_range(0, 99);
      if (p < 4) begin
        queue_cmd(make_word(spfa_pkg::OP_CLEAR, 0, 0, 0, 0));
      end else if (p < 8) begin
        queue_cmd(make_word(OP_UNUSED, $urandom_range(0, NODES - 1),
                            $urandom_range(0, NODES - 1), rand_weight(), 0));
      end else if (p < 80) begin
        queue_cmd(make_word(spfa_pkg::OP_ADD, $urandom_range(0, NODES - 1),
                            $urandom_range(0, NODES - 1), rand_weight(), 0));
      end else begin
        queue_cmd(make_word(spfa_pkg::OP_RUN, 0, 0, 0, $urandom_range(0, NODES - 1)));
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (burst_left == 0) begin
        gap_left = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_ch.data <= cmd_q.pop_front();
        in_ch.valid <= 1'b1;
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
      end
    end
  end

  // receiver: long hold-off once outputs are flowing
  int cyc_cnt;
  int pause_left;
  bit pause_done;
  always @(posedge clk) begin
    if (rst) begin
      cyc_cnt <= 0;
      pause_left <= 0;
      pause_done <= 1'b0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (pause_left > 0) begin
        pause_left <= pause_left - 1;
      end else if (!pause_done && cyc_cnt >= 1000 && out_ch.valid) begin
        pause_left <= PAUSE_CYCLES;
        pause_done <= 1'b1;
      end
    end
  end

  int rcv_cnt = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      rcv_cnt++;
      out_ch.ready <= (pause_left == 0) && ((rcv_cnt % 9) < 6);
    end
  end

  always @(posedge clk) begin
    spfa_pkg::out_word_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          $error("unexpected word node_index=%0d", out_ch.data.node_index);
          fail_cnt++;
        end else begin
          want = exp_q.pop_front();
          if (out_ch.data.node_index !== want.node_index) begin
            $error("node_index expected %0d actual %0d", want.node_index,
                   out_ch.data.node_index);
            fail_cnt++;
          end
          if (out_ch.data.distance !== want.distance) begin
            $error("distance expected %0d actual %0d", want.distance, out_ch.data.distance);
            fail_cnt++;
          end
          if (out_ch.data.reachable !== want.reachable) begin
            $error("reachable expected %0d actual %0d", want.reachable,
                   out_ch.data.reachable);
            fail_cnt++;
          end
          if (out_ch.data.negative_cycle !== want.negative_cycle) begin
            $error("negative_cycle expected %0d actual %0d", want.negative_cycle,
                   out_ch.data.negative_cycle);
            fail_cnt++;
          end
          if (out_ch.data.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_ch.data.last);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.data);
      end
    end
  end

  initial begin
    while (!stim_done) @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && exp_q.size() == 0) $display("tb_spfa_shortest_paths OK");
    else $display("tb_spfa_shortest_paths NOT OK");
    $finish;
  end

  initial begin
    #(400_000_000);
    $display("tb_spfa_shortest_paths NOT OK");
    $finish;
  end
endmodule

>>> filelist.f
sv/spfa_pkg.sv
sv/spfa_in_if.sv
sv/spfa_out_if.sv
sv/spfa_shortest_paths.sv
sim/tb_spfa_shortest_paths.sv
